// File: hdl/fpmds_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpmds_pkg: shared types and constants
// Word types, operation codes and limits for the fixed-point unit.
// ---------------------------------------------------------------------------
package fpmds_pkg;

	localparam int unsigned NumCells = 32;
	localparam int unsigned WordW = 32;

	typedef enum logic [2:0] {
		OP_FIXMUL  = 3'd0,
		OP_FRACMUL = 3'd1,
		OP_FIXDIV  = 3'd2,
		OP_FRACDIV = 3'd3,
		OP_URATIO  = 3'd4,
		OP_SQRT    = 3'd5
	} op_t;

	localparam logic [31:0] PosMax = 32'h7fffffff;
	localparam logic [31:0] NegMax = 32'h80000000;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] a;
		logic [31:0] b;
	} in_word_t;

	typedef struct packed {
		logic [31:0] result;
		logic        clamped;
	} out_word_t;

	// Word carried from cell to cell down the chain
	typedef struct packed {
		logic        vld;
		logic [2:0]  op;
		logic        neg;
		logic        zdiv;
		logic        aneg;
		logic [63:0] rem;   // divide: remainder, sqrt: remaining radicand
		logic [63:0] num;   // divide: numerator bits still to shift in
		logic [33:0] den;   // divisor (divide) or unused
		logic [63:0] quo;   // quotient / root bits so far
		logic [63:0] prod;  // multiply result passed through
	} cell_t;

endpackage
`default_nettype wire

// File: hdl/fixed_point_mul_div_sqrt_unit_core.sv
`default_nettype none
// Path: input accept to output word valid runs through the front register and
// 32 chain cells, the last of which holds the output word; two quotient
// or root bits per cell.
// Throughput: one word per cycle; the whole chain advances together and
// stalls only when the output register is full and not taken.
// Reset: arst_n clears every chain register; no word is in flight.
// ---------------------------------------------------------------------------
// fixed_point_mul_div_sqrt_unit_core: fixed-point multiply/divide/root
// Pipelined chain of cells producing one rounded 32-bit result per word.
// ---------------------------------------------------------------------------
module fixed_point_mul_div_sqrt_unit_core import fpmds_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_word_t out_data
);
	cell_t     chain [NumCells+1];
	out_word_t res;
	logic      en;

	// chain moves when the output slot is free or being emptied
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	fpmds_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(in_valid),
		.in_w(in_data), .head_s1(chain[0])
	);

	for (genvar g = 0; g < NumCells; g++) begin : g_cell
		fpmds_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .prev(chain[g]), .nxt_q(chain[g+1])
		);
	end

	fpmds_back u_back (.tail(chain[NumCells]), .res(res));

	assign out_valid = chain[NumCells].vld;
	assign out_data = res;
endmodule
`default_nettype wire

// File: hdl/fpmds_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpmds_front: operand preparation
// Magnitudes, signs, multiply product and initial chain word.
// ---------------------------------------------------------------------------
module fpmds_front import fpmds_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     in_vld,
	input  in_word_t      in_w,
	output cell_t         head_s1
);
	logic [32:0] ma, mb;
	logic [63:0] prod;
	logic        sgn;
	cell_t       c;

	// magnitudes of two's complement operands, raw for unsigned ops
	always_comb begin
		sgn = (in_w.op == OP_URATIO) || (in_w.op == OP_SQRT);
		ma  = (!sgn && in_w.a[31]) ? 33'h100000000 - {1'b0, in_w.a} : {1'b0, in_w.a};
		mb  = (!sgn && in_w.b[31]) ? 33'h100000000 - {1'b0, in_w.b} : {1'b0, in_w.b};
		prod = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
		c = '0;
		c.vld  = in_vld;
		c.op   = in_w.op;
		c.neg  = !sgn && (in_w.a[31] ^ in_w.b[31]);
		c.aneg = in_w.a[31];
		c.zdiv = (in_w.b == '0);
		c.prod = prod;
		c.den  = {1'b0, mb};
		// numerator n is ma<<16 or ma<<30, held as 2n; root radicand is a<<30
		unique case (in_w.op) inside
			OP_FIXDIV, OP_URATIO: c.num = {14'd0, ma, 17'd0};
			OP_FRACDIV:           c.num = {ma, 31'd0};
			OP_SQRT:              c.num = {2'b00, in_w.a, 30'd0};
			default:              c.num = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s1 <= '0;
		end else if (en) begin
			head_s1 <= c;
		end
	end
endmodule
`default_nettype wire

// File: hdl/fpmds_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpmds_cell: one step of the divide / root chain
// Divide: two quotient bits per cell by restoring steps on 2n / d.
// Root: two result bits per cell (one bit pair of radicand each step).
// ---------------------------------------------------------------------------
module fpmds_cell import fpmds_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  cell_t     prev,
	output cell_t     nxt_q
);
	cell_t c;
	logic [65:0] t;
	logic [65:0] rr;

	// two dependent steps per cell
	always_comb begin
		c = prev;
		rr = '0;
		t = '0;
		for (int k = 0; k < 2; k++) begin
			if (c.op == OP_SQRT) begin
				// radicand bit pair from top of num
				rr = {c.rem[63:0], c.num[63:62]};
				t  = rr - {c.quo[63:0], 2'b01};
				c.num = {c.num[61:0], 2'b00};
				if (!t[65]) begin
					c.rem = t[63:0];
					c.quo = {c.quo[62:0], 1'b1};
				end else begin
					c.rem = rr[63:0];
					c.quo = {c.quo[62:0], 1'b0};
				end
			end else begin
				rr = {1'b0, c.rem, c.num[63]};
				t  = rr - {32'd0, c.den};
				c.num = {c.num[62:0], 1'b0};
				if (!t[65]) begin
					c.rem = t[63:0];
					c.quo = {c.quo[62:0], 1'b1};
				end else begin
					c.rem = rr[63:0];
					c.quo = {c.quo[62:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_q <= '0;
		end else if (en) begin
			nxt_q <= c;
		end
	end
endmodule
`default_nettype wire

// File: hdl/fpmds_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpmds_back: rounding, sign and saturation
// Turns the chain tail into the result word.
// ---------------------------------------------------------------------------
module fpmds_back import fpmds_pkg::*; (
	input  cell_t     tail,
	output out_word_t res
);
	logic [63:0] q;
	logic        flg;
	logic [31:0] r;

	always_comb begin
		q = '0;
		flg = 1'b0;
		r = '0;
		case (tail.op)
			OP_FIXMUL:  q = (tail.prod + 64'h8000) >> 16;
			OP_FRACMUL: q = (tail.prod + 64'h20000000) >> 30;
			// quotient of 2n by d; round = (q+1)>>1
			default:    q = (tail.quo + 64'd1) >> 1;
		endcase
		if (tail.op == OP_SQRT) begin
			// root carries 32 fractional bits: keep one, round half up (no exact ties)
			r = 32'(((tail.quo >> 31) + 64'd1) >> 1);
		end else if ((tail.op == OP_FIXDIV || tail.op == OP_FRACDIV) && tail.zdiv) begin
			flg = 1'b1;
			r = tail.aneg ? NegMax : PosMax;
		end else if (tail.op == OP_URATIO && tail.zdiv) begin
			flg = 1'b1;
			r = PosMax;
		end else if (tail.op <= OP_URATIO) begin
			if (!tail.neg) begin
				if (q > 64'(PosMax)) begin
					flg = 1'b1;
					r = PosMax;
				end else begin
					r = q[31:0];
				end
			end else if (q > 64'(NegMax)) begin
				flg = 1'b1;
				r = NegMax;
			end else begin
				r = 32'd0 - q[31:0];
			end
		end
		res.result = r;
		res.clamped = flg;
	end
endmodule
`default_nettype wire
